[src/analog_input_scale_and_hysteresis_top_assert.svh]
// assertion macros shared by the analog input scaling block
`ifndef ANALOG_INPUT_SCALE_AND_HYSTERESIS_TOP_ASSERT_SVH
`define ANALOG_INPUT_SCALE_AND_HYSTERESIS_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define AISH_ASSERT_IMPLY(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define AISH_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/aish_pkg.sv]
// types and constants of the analog input scaling block
package aish_pkg;

	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 16;
	localparam int COEF_W   = 16;
	localparam int MODE_W   = 3;
	localparam int IDX_W    = 3;
	localparam int PROD_W   = 28;
	localparam int NUM_W    = 31;

	localparam logic [MODE_W-1:0] MODE_RAW      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_VOLT     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CURR     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LOW_OHM  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HIGH_OHM = 3'd4;

	localparam logic [IDX_W-1:0] REG_INPUT_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_VOLT_COEF    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CURR_COEF    = 3'd2;
	localparam logic [IDX_W-1:0] REG_LOW_OHM_COEF = 3'd3;
	localparam logic [IDX_W-1:0] REG_HIGH_OHM_COEF = 3'd4;
	localparam logic [IDX_W-1:0] REG_THR_LOWER    = 3'd5;
	localparam logic [IDX_W-1:0] REG_THR_UPPER    = 3'd6;

	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
	localparam logic [LEVEL_W-1:0]  LEVEL_SAT  = 16'hFFFF;

	typedef enum logic [1:0] {
		SCALE_ONE = 2'd0,
		SCALE_34  = 2'd1,
		SCALE_80  = 2'd2
	} scale_t;

	typedef struct packed {
		logic                start;
		logic [COEF_W-1:0]   mult_a;
		logic [SAMPLE_W-1:0] mult_b;
		scale_t              scale;
		logic [COEF_W-1:0]   divisor;
	} md_req_t;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] quotient;
	} md_rsp_t;

endpackage

[src/aish_in_if.sv]
// input channel: one sample with the supply voltage
interface aish_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] sample;
	logic [11:0] supply_mv;

	modport source (output valid, output sample, output supply_mv, input ready);
	modport sink (input valid, input sample, input supply_mv, output ready);
endinterface

[src/aish_out_if.sv]
// output channel: converted level with trigger state
interface aish_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] level;
	logic        digital_state;

	modport source (output valid, output level, output digital_state, input ready);
	modport sink (input valid, input level, input digital_state, output ready);
endinterface

[src/aish_muldiv.sv]
// bit-serial multiply, constant scale and restoring divide with saturation
`include "analog_input_scale_and_hysteresis_top_assert.svh"

module aish_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  aish_pkg::md_req_t req,
	output aish_pkg::md_rsp_t rsp
);

	typedef enum logic [3:0] {
		MD_IDLE  = 4'b0001,
		MD_MUL   = 4'b0010,
		MD_SCALE = 4'b0100,
		MD_DIV   = 4'b1000
	} md_state_t;

	localparam logic [4:0] MUL_LAST = 5'(aish_pkg::SAMPLE_W - 1);
	localparam logic [4:0] DIV_LAST = 5'(aish_pkg::NUM_W - 1);

	md_state_t                       state_q;
	logic [4:0]                      cnt_q;
	logic                            done_q;
	logic [aish_pkg::COEF_W-1:0]     mcand_q;
	logic [aish_pkg::SAMPLE_W-1:0]   mplier_q;
	logic [aish_pkg::PROD_W-1:0]     acc_q;
	aish_pkg::scale_t                scale_q;
	logic [aish_pkg::COEF_W-1:0]     div_q;
	logic [aish_pkg::NUM_W-1:0]      num_q;
	logic [aish_pkg::COEF_W-1:0]     rem_q;
	logic [aish_pkg::LEVEL_W-1:0]    quo_q;
	logic                            ovf_q;

	logic [aish_pkg::PROD_W-1:0]     acc_next;
	logic [32:0]                     x34;
	logic [33:0]                     x80;
	logic [aish_pkg::NUM_W-1:0]      scaled;
	logic [aish_pkg::COEF_W:0]       trial;
	logic [aish_pkg::COEF_W:0]       diff;
	logic                            ge;
	logic [aish_pkg::COEF_W-1:0]     rem_next;

	// msb-first shift and add
	assign acc_next = {acc_q[aish_pkg::PROD_W-2:0], 1'b0}
		+ (mplier_q[aish_pkg::SAMPLE_W-1]
			? {{(aish_pkg::PROD_W - aish_pkg::COEF_W){1'b0}}, mcand_q}
			: {aish_pkg::PROD_W{1'b0}});

	// times 34 is 32 + 2, times 80 is 64 + 16
	assign x34 = {acc_q, 5'b0} + {4'b0, acc_q, 1'b0};
	assign x80 = {acc_q, 6'b0} + {2'b0, acc_q, 4'b0};

	always_comb begin
		case (scale_q)
			aish_pkg::SCALE_34: scaled = x34[aish_pkg::NUM_W-1:0];
			aish_pkg::SCALE_80: scaled = x80[aish_pkg::NUM_W-1:0];
			default: scaled = {{(aish_pkg::NUM_W - aish_pkg::PROD_W){1'b0}}, acc_q};
		endcase
	end

	// a zero divisor gives an all-ones quotient, which saturates below
	assign trial    = {rem_q, num_q[aish_pkg::NUM_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign rem_next = ge ? diff[aish_pkg::COEF_W-1:0] : trial[aish_pkg::COEF_W-1:0];

	assign rsp.done     = done_q;
	assign rsp.quotient = ovf_q ? aish_pkg::LEVEL_SAT : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= 5'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == MD_DIV) && (cnt_q == 5'd0);
			case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_MUL;
						cnt_q   <= MUL_LAST;
					end
				end
				MD_MUL: begin
					if (cnt_q == 5'd0) begin
						state_q <= MD_SCALE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				MD_SCALE: begin
					state_q <= MD_DIV;
					cnt_q   <= DIV_LAST;
				end
				MD_DIV: begin
					if (cnt_q == 5'd0) begin
						state_q <= MD_IDLE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: state_q <= MD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					mcand_q  <= req.mult_a;
					mplier_q <= req.mult_b;
					acc_q    <= '0;
					scale_q  <= req.scale;
					div_q    <= req.divisor;
				end
			end
			MD_MUL: begin
				acc_q    <= acc_next;
				mplier_q <= {mplier_q[aish_pkg::SAMPLE_W-2:0], 1'b0};
			end
			MD_SCALE: begin
				num_q <= scaled;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			MD_DIV: begin
				num_q <= {num_q[aish_pkg::NUM_W-2:0], 1'b0};
				rem_q <= rem_next;
				// any quotient bit pushed past bit 15 means saturation
				quo_q <= {quo_q[aish_pkg::LEVEL_W-2:0], ge};
				ovf_q <= ovf_q | quo_q[aish_pkg::LEVEL_W-1];
			end
			default: begin
			end
		endcase
	end

	`AISH_ASSERT_IMPLY(a_start_idle, clk, arst_n, req.start, state_q == MD_IDLE, "start while unit busy")
	`AISH_ASSERT_IMPLY(a_done_after_div, clk, arst_n, done_q, $past(state_q == MD_DIV), "done without divide")
	`AISH_ASSERT_IMPLY(a_scale_after_mul, clk, arst_n, state_q == MD_SCALE, $past(state_q == MD_MUL) && ($past(cnt_q) == 5'd0), "scale step out of order")

endmodule

[src/analog_input_scale_and_hysteresis_top.sv]
// top level: analog input scaling to a 16-bit level with schmitt trigger
//
//   channel  dir  handshake      payload
//   din      in   valid/ready    sample[11:0], supply_mv[11:0]
//   dout     out  valid/ready    level[15:0], digital_state
//   cfg      in   cfg_we         cfg_index[2:0], cfg_wdata[15:0]
//
// raw and undefined modes: the sample is registered as the result directly
// scaled modes: 12 multiply steps, 1 scale step and 31 divide steps
// of the shared bit-serial unit plus handover
// the result sits in an output register; a stalled dout holds it and the block
// waits with the next result until it is taken; din is ready only while idle
// reset clears control state and the trigger and sets the configuration defaults
`include "analog_input_scale_and_hysteresis_top_assert.svh"

module analog_input_scale_and_hysteresis_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [aish_pkg::IDX_W-1:0]   cfg_index,
	input  logic [aish_pkg::COEF_W-1:0]  cfg_wdata,
	aish_in_if.sink                      din,
	aish_out_if.source                   dout
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} st_state_t;

	st_state_t                      state_q;
	logic [aish_pkg::MODE_W-1:0]    input_mode_q;
	logic [aish_pkg::COEF_W-1:0]    volt_coef_q;
	logic [aish_pkg::COEF_W-1:0]    curr_coef_q;
	logic [aish_pkg::COEF_W-1:0]    low_ohm_coef_q;
	logic [aish_pkg::COEF_W-1:0]    high_ohm_coef_q;
	logic [aish_pkg::LEVEL_W-1:0]   thr_lower_q;
	logic [aish_pkg::LEVEL_W-1:0]   thr_upper_q;
	logic                           trig_q;
	logic                           out_valid_q;
	logic [aish_pkg::LEVEL_W-1:0]   out_level_q;
	logic [aish_pkg::LEVEL_W-1:0]   res_level_q;

	logic                           accept;
	logic                           out_load;
	logic                           raw;
	logic                           trig_next;
	logic [aish_pkg::SAMPLE_W-1:0]  ohm_den;
	aish_pkg::md_req_t              req;
	aish_pkg::md_rsp_t              rsp;

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || dout.ready);

	assign dout.valid         = out_valid_q;
	assign dout.level         = out_level_q;
	assign dout.digital_state = trig_q;

	// full scale gives a zero divisor and so saturates
	assign ohm_den = aish_pkg::FULL_SCALE - din.sample;

	always_comb begin
		raw         = 1'b0;
		req.start   = 1'b0;
		req.mult_a  = {4'b0, din.sample};
		req.mult_b  = din.supply_mv;
		req.scale   = aish_pkg::SCALE_ONE;
		req.divisor = {4'b0, ohm_den};
		case (input_mode_q)
			aish_pkg::MODE_VOLT: begin
				req.scale   = aish_pkg::SCALE_34;
				req.divisor = volt_coef_q;
			end
			aish_pkg::MODE_CURR: begin
				req.scale   = aish_pkg::SCALE_80;
				req.divisor = curr_coef_q;
			end
			aish_pkg::MODE_LOW_OHM: begin
				req.mult_a = low_ohm_coef_q;
				req.mult_b = din.sample;
			end
			aish_pkg::MODE_HIGH_OHM: begin
				req.mult_a = high_ohm_coef_q;
				req.mult_b = din.sample;
			end
			default: raw = 1'b1;
		endcase
		req.start = accept && !raw;
	end

	assign trig_next = trig_q ? !(res_level_q < thr_lower_q) : (res_level_q > thr_upper_q);

	aish_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q    <= aish_pkg::MODE_RAW;
			volt_coef_q     <= 16'd45946;
			curr_coef_q     <= 16'd41769;
			low_ohm_coef_q  <= 16'd1000;
			high_ohm_coef_q <= 16'd4000;
			thr_lower_q     <= 16'd1000;
			thr_upper_q     <= 16'd2000;
		end else if (cfg_we) begin
			case (cfg_index)
				aish_pkg::REG_INPUT_MODE:    input_mode_q    <= cfg_wdata[aish_pkg::MODE_W-1:0];
				aish_pkg::REG_VOLT_COEF:     volt_coef_q     <= cfg_wdata;
				aish_pkg::REG_CURR_COEF:     curr_coef_q     <= cfg_wdata;
				aish_pkg::REG_LOW_OHM_COEF:  low_ohm_coef_q  <= cfg_wdata;
				aish_pkg::REG_HIGH_OHM_COEF: high_ohm_coef_q <= cfg_wdata;
				aish_pkg::REG_THR_LOWER:     thr_lower_q     <= cfg_wdata;
				aish_pkg::REG_THR_UPPER:     thr_upper_q     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			trig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= raw ? ST_DONE : ST_CALC;
					end
				end
				ST_CALC: begin
					if (rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				trig_q      <= trig_next;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && raw) begin
			res_level_q <= {4'b0, din.sample};
		end else if (state_q == ST_CALC && rsp.done) begin
			res_level_q <= rsp.quotient;
		end
		if (out_load) begin
			out_level_q <= res_level_q;
		end
	end

	`AISH_ASSERT_IMPLY(a_done_in_calc, clk, arst_n, rsp.done, state_q == ST_CALC, "unit finished while not waited for")
	`AISH_ASSERT_NEXT(a_load_shows, clk, arst_n, out_load, dout.valid, "loaded result not presented")
	`AISH_ASSERT_IMPLY(a_trig_rise, clk, arst_n, $rose(trig_q), $past(res_level_q) > $past(thr_upper_q), "trigger rose without crossing upper threshold")

endmodule

[tb/analog_input_scale_and_hysteresis_top_test.sv]
// self-checking testbench of the analog input scaling and schmitt trigger block
module analog_input_scale_and_hysteresis_top_test;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 120;
	localparam int END_SETTLE  = 60;
	localparam logic [31:0] VOLT_GAIN = 32'd34;
	localparam logic [31:0] CURR_GAIN = 32'd80;
	localparam logic [aish_pkg::MODE_W-1:0] MODE_SPARE_5 = 3'd5;
	localparam logic [aish_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
	localparam logic [aish_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;
	localparam logic [aish_pkg::IDX_W-1:0]  REG_NONE     = 3'd7;

	typedef struct packed {
		logic [aish_pkg::LEVEL_W-1:0] level;
		logic                         state;
	} level_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [aish_pkg::IDX_W-1:0]  cfg_index;
	logic [aish_pkg::COEF_W-1:0] cfg_wdata;

	aish_in_if  in_ch();
	aish_out_if out_ch();

	analog_input_scale_and_hysteresis_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.din       (in_ch),
		.dout      (out_ch)
	);

	// mirror of the configuration and the trigger
	logic [aish_pkg::MODE_W-1:0] mode_r      = aish_pkg::MODE_RAW;
	logic [aish_pkg::COEF_W-1:0] volt_coef_r = 16'd45946;
	logic [aish_pkg::COEF_W-1:0] curr_coef_r = 16'd41769;
	logic [aish_pkg::COEF_W-1:0] low_ohm_r   = 16'd1000;
	logic [aish_pkg::COEF_W-1:0] high_ohm_r  = 16'd4000;
	logic [aish_pkg::COEF_W-1:0] thr_lo_r    = 16'd1000;
	logic [aish_pkg::COEF_W-1:0] thr_hi_r    = 16'd2000;
	logic                        trig_r      = 1'b0;

	level_result_t pending_results[$];
	int  mismatch_count = 0;
	int  cycle_count = 0;
	bit  send_gaps_on;
	bit  sink_stalls_on;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("analog_input_scale_and_hysteresis_top_test: errors");
		$finish;
	end

	function automatic logic [aish_pkg::LEVEL_W-1:0] scaled_level(
			input logic [aish_pkg::SAMPLE_W-1:0] s,
			input logic [aish_pkg::SAMPLE_W-1:0] mv);
		logic [31:0] num;
		logic [31:0] den;
		logic [31:0] quo;
		num = 32'd0;
		den = 32'd1;
		case (mode_r)
			aish_pkg::MODE_VOLT: begin
				num = 32'(s) * 32'(mv) * VOLT_GAIN;
				den = 32'(volt_coef_r);
			end
			aish_pkg::MODE_CURR: begin
				num = 32'(s) * 32'(mv) * CURR_GAIN;
				den = 32'(curr_coef_r);
			end
			aish_pkg::MODE_LOW_OHM, aish_pkg::MODE_HIGH_OHM: begin
				if (s == aish_pkg::FULL_SCALE)
					return aish_pkg::LEVEL_SAT;
				num = 32'(mode_r == aish_pkg::MODE_LOW_OHM ? low_ohm_r : high_ohm_r)
					* 32'(s);
				den = 32'(aish_pkg::FULL_SCALE) - 32'(s);
			end
			default: return 16'(s);
		endcase
		if (den == 32'd0)
			return aish_pkg::LEVEL_SAT;
		quo = num / den;
		return (quo > 32'(aish_pkg::LEVEL_SAT)) ? aish_pkg::LEVEL_SAT
			: quo[aish_pkg::LEVEL_W-1:0];
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [aish_pkg::COEF_W-1:0] random_coef();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'd1;
		return 16'($urandom_range(1, 65535));
	endfunction

	// prediction on every accepted item, comparison on every accepted result
	always @(posedge clk) begin : result_check
		logic [aish_pkg::LEVEL_W-1:0] lvl;
		level_result_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				lvl = scaled_level(in_ch.sample, in_ch.supply_mv);
				if (trig_r) begin
					if (lvl < thr_lo_r)
						trig_r = 1'b0;
				end else if (lvl > thr_hi_r) begin
					trig_r = 1'b1;
				end
				pending_results.push_back('{level: lvl, state: trig_r});
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected item level %0d state %0b", $time,
						out_ch.level, out_ch.digital_state);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_ch.level !== want.level) begin
						$display("%0t: level expected %0d actual %0d", $time,
							want.level, out_ch.level);
						mismatch_count++;
					end
					if (out_ch.digital_state !== want.state) begin
						$display("%0t: digital_state expected %0b actual %0b", $time,
							want.state, out_ch.digital_state);
						mismatch_count++;
					end
				end
			end
		end
	end

	// receiver pacing, with a long hold-off on request
	initial begin : sink_pacing
		int stall_left;
		int hold_left;
		bit hold_seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 1'b0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (!hold_req)
				hold_seen = 1'b0;
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = 1'b1;
				if (sink_stalls_on)
					stall_left = idle_len();
			end
		end
	end

	// offers one item from a falling edge and returns at the falling edge after it is taken
	task automatic send_item(input logic [aish_pkg::SAMPLE_W-1:0] s,
			input logic [aish_pkg::SAMPLE_W-1:0] mv);
		int gap;
		gap = send_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.sample = s;
		in_ch.supply_mv = mv;
		in_ch.valid = 1'b1;
		do
			@(posedge clk);
		while (!(in_ch.valid && in_ch.ready));
		@(negedge clk);
	endtask

	task automatic wait_drained(input int settle);
		in_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [aish_pkg::IDX_W-1:0] idx,
			input logic [aish_pkg::COEF_W-1:0] val);
		wait_drained(4);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		case (idx)
			aish_pkg::REG_INPUT_MODE:    mode_r = val[aish_pkg::MODE_W-1:0];
			aish_pkg::REG_VOLT_COEF:     volt_coef_r = val;
			aish_pkg::REG_CURR_COEF:     curr_coef_r = val;
			aish_pkg::REG_LOW_OHM_COEF:  low_ohm_r = val;
			aish_pkg::REG_HIGH_OHM_COEF: high_ohm_r = val;
			aish_pkg::REG_THR_LOWER:     thr_lo_r = val;
			aish_pkg::REG_THR_UPPER:     thr_hi_r = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_random_items(input int count);
		logic [aish_pkg::SAMPLE_W-1:0] s;
		logic [aish_pkg::SAMPLE_W-1:0] mv;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				s = $urandom_range(0, 1) ? aish_pkg::FULL_SCALE : 12'd0;
			else if (r < 18)
				s = $urandom_range(0, 1) ? 12'($urandom_range(4088, 4094)) :
					12'($urandom_range(1, 8));
			else
				s = 12'($urandom_range(0, 4095));
			mv = $urandom_range(0, 2) == 0 ? 12'($urandom_range(0, 4095)) :
				12'($urandom_range(2800, 3600));
			send_item(s, mv);
		end
		wait_drained(4);
	endtask

	task automatic test_reset_state();
		send_item(12'd0, 12'd0);
		send_item(aish_pkg::FULL_SCALE, 12'd4095);
		send_item(12'd2001, 12'd3300);
		send_item(12'd1500, 12'd3300);
		send_item(12'd999, 12'd3300);
		send_item(12'd2000, 12'd3300);
		wait_drained(4);
	endtask

	task automatic test_scaling_modes();
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_VOLT));
		send_item(aish_pkg::FULL_SCALE, 12'd4095);
		write_reg(aish_pkg::REG_VOLT_COEF, 16'd0);
		send_item(12'd1, 12'd1);
		write_reg(aish_pkg::REG_VOLT_COEF, 16'd1);
		send_item(aish_pkg::FULL_SCALE, 12'd4095);

		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_CURR));
		send_item(aish_pkg::FULL_SCALE, 12'd4095);
		write_reg(aish_pkg::REG_CURR_COEF, 16'd0);
		send_item(12'd1, 12'd1);

		// full scale saturates in both resistance ranges
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_LOW_OHM));
		send_item(aish_pkg::FULL_SCALE, 12'd3300);
		write_reg(aish_pkg::REG_LOW_OHM_COEF, 16'hFFFF);
		send_item(12'd4094, 12'd3300);
		send_item(12'd0, 12'd0);
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_HIGH_OHM));
		send_item(12'd2048, 12'd3300);
		send_item(aish_pkg::FULL_SCALE, 12'd3300);

		write_reg(aish_pkg::REG_INPUT_MODE, 16'(MODE_SPARE_5));
		send_item(12'd3000, 12'd1);
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(MODE_SPARE_6));
		send_item(12'd3000, 12'd1);
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(MODE_SPARE_7));
		send_item(12'd3000, 12'd1);

		// lower threshold above the upper one
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_RAW));
		write_reg(aish_pkg::REG_THR_LOWER, 16'd3000);
		write_reg(aish_pkg::REG_THR_UPPER, 16'd100);
		send_item(12'd50, 12'd3300);
		send_item(12'd2000, 12'd3300);
		send_item(12'd3500, 12'd3300);

		write_reg(REG_NONE, 16'hFFFF);
		send_item(12'd100, 12'd3300);
		wait_drained(4);
	endtask

	task automatic test_random_settings();
		logic [aish_pkg::MODE_W-1:0] phase_modes[8];
		logic [aish_pkg::LEVEL_W-1:0] lvl_a;
		logic [aish_pkg::LEVEL_W-1:0] lvl_b;
		logic [aish_pkg::LEVEL_W-1:0] swap;
		phase_modes = '{aish_pkg::MODE_RAW, aish_pkg::MODE_VOLT, aish_pkg::MODE_CURR,
			aish_pkg::MODE_LOW_OHM, aish_pkg::MODE_HIGH_OHM,
			MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0) begin
				write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_VOLT));
				write_reg(aish_pkg::REG_VOLT_COEF, 16'hFFFF);
				write_reg(aish_pkg::REG_CURR_COEF, 16'hFFFF);
				write_reg(aish_pkg::REG_LOW_OHM_COEF, 16'hFFFF);
				write_reg(aish_pkg::REG_HIGH_OHM_COEF, 16'hFFFF);
				write_reg(aish_pkg::REG_THR_LOWER, 16'd0);
				write_reg(aish_pkg::REG_THR_UPPER, 16'hFFFF);
			end else if (phase == 1) begin
				// thresholds crossed at the extremes: the trigger follows almost every item
				write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_CURR));
				write_reg(aish_pkg::REG_VOLT_COEF, 16'd1);
				write_reg(aish_pkg::REG_CURR_COEF, 16'd1);
				write_reg(aish_pkg::REG_LOW_OHM_COEF, 16'd0);
				write_reg(aish_pkg::REG_HIGH_OHM_COEF, 16'd0);
				write_reg(aish_pkg::REG_THR_LOWER, 16'hFFFF);
				write_reg(aish_pkg::REG_THR_UPPER, 16'd0);
			end else begin
				write_reg(aish_pkg::REG_INPUT_MODE, 16'(phase_modes[phase-2]));
				write_reg(aish_pkg::REG_VOLT_COEF, random_coef());
				write_reg(aish_pkg::REG_CURR_COEF, random_coef());
				write_reg(aish_pkg::REG_LOW_OHM_COEF, random_coef());
				write_reg(aish_pkg::REG_HIGH_OHM_COEF, random_coef());
				// thresholds taken from levels this setting really produces
				lvl_a = scaled_level(12'($urandom_range(0, 4094)), 12'($urandom_range(2800, 3600)));
				lvl_b = scaled_level(12'($urandom_range(0, 4094)), 12'($urandom_range(2800, 3600)));
				if ((lvl_a > lvl_b) != ($urandom_range(0, 5) == 0)) begin
					swap = lvl_a;
					lvl_a = lvl_b;
					lvl_b = swap;
				end
				write_reg(aish_pkg::REG_THR_LOWER, lvl_a);
				write_reg(aish_pkg::REG_THR_UPPER, lvl_b);
			end
			send_random_items(PHASE_ITEMS);
		end
	endtask

	task automatic test_output_backpressure();
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_CURR));
		write_reg(aish_pkg::REG_CURR_COEF, 16'd41769);
		send_gaps_on = 1'b0;
		hold_req = 1'b1;
		for (int i = 0; i < 16; i++)
			send_item(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
		wait_drained(4);
		hold_req = 1'b0;
		send_gaps_on = 1'b1;
	endtask

	task automatic test_full_rate();
		send_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_RAW));
		write_reg(aish_pkg::REG_THR_LOWER, 16'd1000);
		write_reg(aish_pkg::REG_THR_UPPER, 16'd3000);
		send_random_items(60);
		write_reg(aish_pkg::REG_INPUT_MODE, 16'(aish_pkg::MODE_HIGH_OHM));
		send_random_items(60);
		send_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aish_pkg::REG_INPUT_MODE;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.supply_mv = '0;
		send_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_scaling_modes();
		test_random_settings();
		test_output_backpressure();
		test_full_rate();
		wait_drained(END_SETTLE);

		if (mismatch_count == 0)
			$display("analog_input_scale_and_hysteresis_top_test: clean");
		else
			$display("analog_input_scale_and_hysteresis_top_test: errors");
		$finish;
	end

endmodule
